// ----- src/cts_pkg.sv -----
package cts_pkg;

    // Scanner modes between bytes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_CBODY,
        MODE_CCLOSE,
        MODE_STR,
        MODE_OPER
    } scan_mode_t;

    // Operators that wait for a possible '=' as the next byte.
    typedef enum logic [1:0] {
        OP_LSS,
        OP_GRE,
        OP_ASSIGN,
        OP_BANG
    } pend_op_t;

    typedef logic [5:0] kind_t;

    localparam kind_t K_IDENT  = 6'd13;
    localparam kind_t K_INT    = 6'd14;
    localparam kind_t K_CHAR   = 6'd15;
    localparam kind_t K_STR    = 6'd16;
    localparam kind_t K_ADD    = 6'd17;
    localparam kind_t K_SUB    = 6'd18;
    localparam kind_t K_MUL    = 6'd19;
    localparam kind_t K_DIV    = 6'd20;
    localparam kind_t K_LSS    = 6'd21;
    localparam kind_t K_LEQ    = 6'd22;
    localparam kind_t K_GRE    = 6'd23;
    localparam kind_t K_GEQ    = 6'd24;
    localparam kind_t K_ASSIGN = 6'd25;
    localparam kind_t K_EQL    = 6'd26;
    localparam kind_t K_NEQ    = 6'd27;
    localparam kind_t K_SEMI   = 6'd28;
    localparam kind_t K_COMMA  = 6'd29;
    localparam kind_t K_LPAREN = 6'd30;
    localparam kind_t K_RPAREN = 6'd31;
    localparam kind_t K_LBRACK = 6'd32;
    localparam kind_t K_RBRACK = 6'd33;
    localparam kind_t K_LBRACE = 6'd34;
    localparam kind_t K_RBRACE = 6'd35;

    localparam int          NUM_KEYWORDS = 13;
    localparam logic [23:0] LINE_MAX     = 24'hFF_FFFF;
    localparam logic [15:0] LEN_OUT_MAX  = 16'hFFFF;

    // Keywords packed first character highest, in kind order.
    localparam logic [63:0] KW_WORDS [NUM_KEYWORDS] = '{
        64'("const"), 64'("int"), 64'("char"), 64'("void"), 64'("main"),
        64'("if"), 64'("else"), 64'("do"), 64'("while"), 64'("for"),
        64'("scanf"), 64'("printf"), 64'("return")
    };

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        err;
    } token_t;

    function automatic kind_t kw_lookup(input logic [63:0] prefix);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (KW_WORDS[i] == prefix) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

    function automatic kind_t oper_kind(input pend_op_t op);
        kind_t k;
        unique case (op)
            OP_LSS:    k = K_LSS;
            OP_GRE:    k = K_GRE;
            OP_ASSIGN: k = K_ASSIGN;
            default:   k = K_NEQ;
        endcase
        return k;
    endfunction

endpackage

// ----- src/c_subset_token_scanner.sv -----
// C-subset token scanner.
// The input stream carries one source byte per beat: s_tdata[7:0] is the byte and
// s_tuser is the action, 0 for a byte and 1 for end of input, which flushes the
// token being built. The output stream carries one token record per beat, with
// m_tlast high on the final token caused by one input beat.
// An accepted beat is registered, scanned by one level of combinational logic and
// its tokens loaded into a two-entry result register, which presents them; the load
// waits while that register holds tokens that are not being taken. The scanner
// takes one byte per cycle while the receiver keeps up and no beat yields two
// tokens; the only loop is the scan state register, updated once per byte. A byte
// that ends one token and is itself a one-byte operator yields two tokens, which
// leave over two output beats, and the input stage waits for the second beat to go.
// When the receiver holds m_tready low, the result register keeps its tokens,
// the input register fills, and s_tready falls until the receiver takes the last
// token of the run. After reset the scanner is between tokens at offset 0 and
// line 1, and no beat is pending on either side.
module c_subset_token_scanner #(
    parameter int KEYWORD_CHARS = 6,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] start_offset, [47:32] token_length,
                                   // [71:48] src_line
    output logic [6:0]  m_tuser,   // [5:0] token_kind, [6] lexical_error
    output logic        m_tlast    // last_of_run
);
    import cts_pkg::*;

    localparam int PW = 8 * KEYWORD_CHARS;

    // Input register.
    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    // Scanner state.
    scan_mode_t             mode_reg,   mode_next;
    logic [PW-1:0]          prefix_reg, prefix_next;
    logic                   ovf_reg,    ovf_next;
    pend_op_t               pend_reg,   pend_next;
    logic [31:0]            start_reg,  start_next;
    logic [LENGTH_BITS-1:0] len_reg,    len_next;
    logic                   err_reg,    err_next;
    logic                   lz_reg,     lz_next;
    logic [31:0]            pos_reg,    pos_next;
    logic [23:0]            line_reg,   line_next;

    // Result register: up to two tokens, head in slot 0.
    logic [1:0] res_cnt_reg, res_cnt_next;
    token_t     slot0_reg,   slot0_next;
    token_t     slot1_reg,   slot1_next;

    logic   fire;
    logic   out_take;
    logic   first_valid, second_valid;
    token_t first_tok,   second_tok;
    logic   again;

    logic [7:0] c;
    logic is_alpha, is_digit, is_space, is_word, char_ok;

    function automatic logic [15:0] sat_len(input logic [LENGTH_BITS-1:0] l);
        logic [31:0] w;
        w = 32'(l);
        return (w > 32'(LEN_OUT_MAX)) ? LEN_OUT_MAX : w[15:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] l);
        return (l == '1) ? l : l + 1'b1;
    endfunction

    assign out_take = m_tvalid && m_tready;
    // The scan stage advances once the result register is empty or frees this cycle.
    assign fire     = in_valid_reg &&
                      ((res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && m_tready));
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = (res_cnt_reg != 2'd0);
    assign m_tlast  = (res_cnt_reg == 2'd1);
    assign m_tdata  = {slot0_reg.line, slot0_reg.len, slot0_reg.start};
    assign m_tuser  = {slot0_reg.err, slot0_reg.kind};

    assign c        = in_byte_reg;
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit = (c >= "0" && c <= "9");
    assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    assign is_word  = is_alpha || is_digit || (c == "_");
    assign char_ok  = is_word || (c == "+") || (c == "-") || (c == "*") || (c == "/");

    always_comb
    begin
        mode_next    = mode_reg;
        prefix_next  = prefix_reg;
        ovf_next     = ovf_reg;
        pend_next    = pend_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        lz_next      = lz_reg;
        pos_next     = pos_reg;
        line_next    = line_reg;
        first_valid  = 1'b0;
        second_valid = 1'b0;
        first_tok    = '0;
        second_tok   = '0;
        again        = 1'b0;

        first_tok.line  = line_reg;
        second_tok.line = line_reg;

        if (fire)
        begin
            if (in_action_reg)
            begin
                // End of input: the pending token goes out as it stands.
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = ovf_reg ? K_IDENT : kw_lookup(64'(prefix_reg));
                        first_tok.start = start_reg;
                        first_tok.len   = sat_len(len_reg);
                    end
                    MODE_NUM:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = K_INT;
                        first_tok.start = start_reg;
                        first_tok.len   = sat_len(len_reg);
                        first_tok.err   = err_reg;
                    end
                    MODE_CBODY:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = K_CHAR;
                        first_tok.start = start_reg;
                        first_tok.err   = 1'b1;
                    end
                    MODE_CCLOSE:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = K_CHAR;
                        first_tok.start = start_reg;
                        first_tok.len   = sat_len(len_reg);
                        first_tok.err   = 1'b1;
                    end
                    MODE_STR:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = K_STR;
                        first_tok.start = start_reg;
                        first_tok.len   = sat_len(len_reg);
                        first_tok.err   = 1'b1;
                    end
                    MODE_OPER:
                    begin
                        first_valid     = 1'b1;
                        first_tok.start = start_reg;
                        if (pend_reg == OP_BANG)
                        begin
                            first_tok.kind = K_NEQ;
                            first_tok.len  = 16'd2;
                            first_tok.err  = 1'b1;
                        end
                        else
                        begin
                            first_tok.kind = oper_kind(pend_reg);
                            first_tok.len  = 16'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                mode_next = MODE_IDLE;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_word)
                        begin
                            // Only the leading characters take part in keyword matching.
                            if (len_reg < LENGTH_BITS'(KEYWORD_CHARS))
                                prefix_next = {prefix_reg[PW-9:0], c};
                            else
                                ovf_next = 1'b1;
                            len_next = len_inc(len_reg);
                        end
                        else
                        begin
                            first_valid     = 1'b1;
                            first_tok.kind  = ovf_reg ? K_IDENT : kw_lookup(64'(prefix_reg));
                            first_tok.start = start_reg;
                            first_tok.len   = sat_len(len_reg);
                            again           = 1'b1;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (is_digit)
                        begin
                            if (lz_reg)
                                err_next = 1'b1;
                            len_next = len_inc(len_reg);
                        end
                        else
                        begin
                            first_valid     = 1'b1;
                            first_tok.kind  = K_INT;
                            first_tok.start = start_reg;
                            first_tok.len   = sat_len(len_reg);
                            first_tok.err   = err_reg;
                            again           = 1'b1;
                        end
                    end
                    MODE_CBODY:
                    begin
                        start_next = pos_reg;
                        len_next   = LENGTH_BITS'(1);
                        err_next   = !char_ok;
                        mode_next  = MODE_CCLOSE;
                    end
                    MODE_CCLOSE:
                    begin
                        first_valid     = 1'b1;
                        first_tok.kind  = K_CHAR;
                        first_tok.start = start_reg;
                        first_tok.len   = sat_len(len_reg);
                        if (c == "'")
                        begin
                            first_tok.err = err_reg;
                            mode_next     = MODE_IDLE;
                        end
                        else
                        begin
                            // Missing closing quote: flag it and rescan this byte.
                            first_tok.err = 1'b1;
                            again         = 1'b1;
                        end
                    end
                    MODE_STR:
                    begin
                        if (c == "\"")
                        begin
                            first_valid     = 1'b1;
                            first_tok.kind  = K_STR;
                            first_tok.start = start_reg;
                            first_tok.len   = sat_len(len_reg);
                            first_tok.err   = err_reg;
                            mode_next       = MODE_IDLE;
                        end
                        else
                        begin
                            if (c < 8'd32 || c > 8'd126)
                                err_next = 1'b1;
                            len_next = len_inc(len_reg);
                        end
                    end
                    MODE_OPER:
                    begin
                        first_valid     = 1'b1;
                        first_tok.start = start_reg;
                        if (c == "=")
                        begin
                            first_tok.kind = (pend_reg == OP_BANG) ? K_NEQ :
                                             oper_kind(pend_reg) + 6'd1;
                            first_tok.len  = 16'd2;
                            mode_next      = MODE_IDLE;
                        end
                        else
                        begin
                            // A lone bang is reported as a flagged inequality.
                            if (pend_reg == OP_BANG)
                            begin
                                first_tok.kind = K_NEQ;
                                first_tok.len  = 16'd2;
                                first_tok.err  = 1'b1;
                            end
                            else
                            begin
                                first_tok.kind = oper_kind(pend_reg);
                                first_tok.len  = 16'd1;
                            end
                            again = 1'b1;
                        end
                    end
                    default:
                    begin
                        again = 1'b1;
                    end
                endcase

                if (again)
                begin
                    // The byte opens whatever comes next.
                    mode_next  = MODE_IDLE;
                    err_next   = 1'b0;
                    len_next   = '0;
                    start_next = pos_reg;
                    if (is_space)
                    begin
                        if (c == 8'h0A && line_reg != LINE_MAX)
                            line_next = line_reg + 24'd1;
                    end
                    else if (is_alpha || c == "_")
                    begin
                        mode_next   = MODE_IDENT;
                        len_next    = LENGTH_BITS'(1);
                        prefix_next = PW'(c);
                        ovf_next    = 1'b0;
                    end
                    else if (is_digit)
                    begin
                        mode_next = MODE_NUM;
                        len_next  = LENGTH_BITS'(1);
                        lz_next   = (c == "0");
                    end
                    else if (c == "'")
                    begin
                        mode_next = MODE_CBODY;
                    end
                    else if (c == "\"")
                    begin
                        mode_next  = MODE_STR;
                        start_next = pos_reg + 32'd1;
                    end
                    else if (c == "<" || c == ">" || c == "=" || c == "!")
                    begin
                        mode_next = MODE_OPER;
                        pend_next = (c == "<") ? OP_LSS :
                                    (c == ">") ? OP_GRE :
                                    (c == "=") ? OP_ASSIGN : OP_BANG;
                    end
                    else
                    begin
                        second_tok.start = pos_reg;
                        second_tok.len   = 16'd1;
                        second_valid     = 1'b1;
                        unique case (c)
                            "+":     second_tok.kind = K_ADD;
                            "-":     second_tok.kind = K_SUB;
                            "*":     second_tok.kind = K_MUL;
                            "/":     second_tok.kind = K_DIV;
                            ";":     second_tok.kind = K_SEMI;
                            ",":     second_tok.kind = K_COMMA;
                            "(":     second_tok.kind = K_LPAREN;
                            ")":     second_tok.kind = K_RPAREN;
                            "[":     second_tok.kind = K_LBRACK;
                            "]":     second_tok.kind = K_RBRACK;
                            "{":     second_tok.kind = K_LBRACE;
                            "}":     second_tok.kind = K_RBRACE;
                            default: second_valid    = 1'b0;
                        endcase
                    end
                end
                pos_next = pos_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        if (fire)
        begin
            res_cnt_next = 2'(first_valid) + 2'(second_valid);
            slot0_next   = first_valid ? first_tok : second_tok;
            slot1_next   = second_tok;
        end
        else if (out_take)
        begin
            if (res_cnt_reg == 2'd2)
            begin
                slot0_next   = slot1_reg;
                res_cnt_next = 2'd1;
            end
            else
            begin
                res_cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            res_cnt_reg  <= 2'd0;
            mode_reg     <= MODE_IDLE;
            prefix_reg   <= '0;
            ovf_reg      <= 1'b0;
            pend_reg     <= OP_LSS;
            start_reg    <= 32'd0;
            len_reg      <= '0;
            err_reg      <= 1'b0;
            lz_reg       <= 1'b0;
            pos_reg      <= 32'd0;
            line_reg     <= 24'd1;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            res_cnt_reg <= res_cnt_next;
            mode_reg    <= mode_next;
            prefix_reg  <= prefix_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            err_reg     <= err_next;
            lz_reg      <= lz_next;
            pos_reg     <= pos_next;
            line_reg    <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef SYNTHESIS
    // The scan stage never overwrites tokens that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (res_cnt_reg == 2'd0 || (res_cnt_reg == 2'd1 && m_tready)))
        else $error("scan stage fired over undelivered tokens");

    // Taking the first of two tokens leaves the second, marked last.
    a_second_token: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg == 2'd2 && m_tready) |=> (m_tvalid && m_tlast))
        else $error("second token of a run was lost");

    // Every scanned byte advances the offset by exactly one.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_action_reg) |=> (pos_reg == $past(pos_reg) + 32'd1))
        else $error("byte offset did not advance");

    // Line numbers start at one and never wrap to zero.
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[71:48] != 24'd0))
        else $error("token carries line zero");
`endif

endmodule

// ----- tb/sv/tb_c_subset_token_scanner.sv -----
module tb_c_subset_token_scanner;

    import cts_pkg::*;

    // The scanner is built with its default keyword width.
    localparam int KW_CHARS = 6;

    // The run fails if this many cycles go by with no beat accepted on either side.
    localparam int IDLE_LIMIT = 5000;

    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    // Input beat actions, carried on s_tuser.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // One expected or observed token record, with its end-of-run marker.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        err;
        logic        last;
    } tok_rec_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_byte
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] start_offset, [47:32] token_length,
                            // [71:48] src_line
    logic [6:0]  m_tuser;   // [5:0] token_kind, [6] lexical_error
    logic        m_tlast;   // last_of_run

    c_subset_token_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Keyword spellings in kind order, and the vocabulary the random source draws on.
    string kw_names [NUM_KEYWORDS] = '{
        "const", "int", "char", "void", "main", "if", "else",
        "do", "while", "for", "scanf", "printf", "return"
    };
    string op_texts [20] = '{
        "+", "-", "*", "/", "<", "<=", ">", ">=", "=", "==",
        "!=", "!", ";", ",", "(", ")", "[", "]", "{", "}"
    };
    logic [7:0] blank_bytes [6] = '{" ", "\t", "\n", "\r", 8'h0B, 8'h0C};

    // Tokens predicted for accepted beats and not yet seen on the output.
    tok_rec_t expected_tokens[$];

    int  mismatches   = 0;
    int  sent_items   = 0;
    int  stall_cycles = 0;
    bit  src_idle_en  = 1'b1;
    bit  sink_idle_en = 1'b1;
    bit  hold_req     = 1'b0;

    // Scanner state as the testbench tracks it.
    scan_mode_t  mode_r;
    logic [63:0] kw_acc;
    logic        kw_ovf;
    pend_op_t    op_r;
    logic [31:0] tok_start_r;
    logic [15:0] tok_len_r;
    logic        tok_err_r;
    logic        lead_zero_r;
    logic [31:0] pos_r;
    logic [23:0] line_r;
    int          step_count;

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == " " || (c >= "\t" && c <= "\r");
    endfunction

    // Bytes that make a clean char constant value.
    function automatic logic char_value_ok(logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == "_" || c == "+" || c == "-" ||
               c == "*" || c == "/";
    endfunction

    // Packs a spelling with its first character in the highest byte used.
    function automatic logic [63:0] pack_text(string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++) begin
            w = {w[55:0], s[i]};
        end
        return w;
    endfunction

    function automatic kind_t op_alone_kind(pend_op_t op);
        case (op)
            OP_LSS:    return K_LSS;
            OP_GRE:    return K_GRE;
            OP_ASSIGN: return K_ASSIGN;
            default:   return K_NEQ;
        endcase
    endfunction

    function automatic kind_t op_with_eq_kind(pend_op_t op);
        case (op)
            OP_LSS:    return K_LEQ;
            OP_GRE:    return K_GEQ;
            OP_ASSIGN: return K_EQL;
            default:   return K_NEQ;
        endcase
    endfunction

    task automatic push_token(kind_t k, logic [31:0] st, logic [15:0] ln, logic e);
        tok_rec_t r;
        r.kind  = k;
        r.start = st;
        r.len   = ln;
        r.line  = line_r;
        r.err   = e;
        r.last  = 1'b0;
        expected_tokens.insert(expected_tokens.size(), r);
        step_count++;
    endtask

    task automatic bump_len();
        if (tok_len_r != LEN_OUT_MAX) begin
            tok_len_r = tok_len_r + 1'b1;
        end
    endtask

    // An identifier is a keyword only when its whole spelling fit in the prefix.
    task automatic close_word();
        kind_t k;
        k = K_IDENT;
        if (!kw_ovf) begin
            for (int i = 0; i < NUM_KEYWORDS; i++) begin
                if (pack_text(kw_names[i]) == kw_acc) begin
                    k = kind_t'(i);
                end
            end
        end
        push_token(k, tok_start_r, tok_len_r, 1'b0);
    endtask

    // A pending operator not followed by '='; a lone bang still reports as a flagged !=.
    task automatic close_operator();
        if (op_r == OP_BANG) begin
            push_token(K_NEQ, tok_start_r, 16'd2, 1'b1);
        end else begin
            push_token(op_alone_kind(op_r), tok_start_r, 16'd1, 1'b0);
        end
    endtask

    // Scans a byte that arrives between tokens.
    task automatic begin_token(logic [7:0] c, logic [31:0] pos);
        mode_r      = MODE_IDLE;
        tok_err_r   = 1'b0;
        tok_len_r   = '0;
        tok_start_r = pos;
        if (is_blank(c)) begin
            if (c == "\n" && line_r != LINE_MAX) begin
                line_r = line_r + 1'b1;
            end
        end else if (is_letter(c) || c == "_") begin
            mode_r    = MODE_IDENT;
            tok_len_r = 16'd1;
            kw_acc    = {56'd0, c};
            kw_ovf    = 1'b0;
        end else if (is_digit(c)) begin
            mode_r      = MODE_NUM;
            tok_len_r   = 16'd1;
            lead_zero_r = (c == "0");
        end else if (c == "'") begin
            mode_r = MODE_CBODY;
        end else if (c == "\"") begin
            mode_r      = MODE_STR;
            tok_start_r = pos + 1;
        end else if (c == "<") begin
            mode_r = MODE_OPER;
            op_r   = OP_LSS;
        end else if (c == ">") begin
            mode_r = MODE_OPER;
            op_r   = OP_GRE;
        end else if (c == "=") begin
            mode_r = MODE_OPER;
            op_r   = OP_ASSIGN;
        end else if (c == "!") begin
            mode_r = MODE_OPER;
            op_r   = OP_BANG;
        end else begin
            // One-byte operators go out at once; anything else is dropped.
            case (c)
                "+":     push_token(K_ADD,    pos, 16'd1, 1'b0);
                "-":     push_token(K_SUB,    pos, 16'd1, 1'b0);
                "*":     push_token(K_MUL,    pos, 16'd1, 1'b0);
                "/":     push_token(K_DIV,    pos, 16'd1, 1'b0);
                ";":     push_token(K_SEMI,   pos, 16'd1, 1'b0);
                ",":     push_token(K_COMMA,  pos, 16'd1, 1'b0);
                "(":     push_token(K_LPAREN, pos, 16'd1, 1'b0);
                ")":     push_token(K_RPAREN, pos, 16'd1, 1'b0);
                "[":     push_token(K_LBRACK, pos, 16'd1, 1'b0);
                "]":     push_token(K_RBRACK, pos, 16'd1, 1'b0);
                "{":     push_token(K_LBRACE, pos, 16'd1, 1'b0);
                "}":     push_token(K_RBRACE, pos, 16'd1, 1'b0);
                default: ;
            endcase
        end
    endtask

    // End of input: whatever is pending goes out as it stands.
    task automatic flush_token();
        case (mode_r)
            MODE_IDENT:  close_word();
            MODE_NUM:    push_token(K_INT,  tok_start_r, tok_len_r, tok_err_r);
            MODE_CBODY:  push_token(K_CHAR, tok_start_r, 16'd0, 1'b1);
            MODE_CCLOSE: push_token(K_CHAR, tok_start_r, tok_len_r, 1'b1);
            MODE_STR:    push_token(K_STR,  tok_start_r, tok_len_r, 1'b1);
            MODE_OPER:   close_operator();
            default:     ;
        endcase
        mode_r = MODE_IDLE;
    endtask

    // Works out the tokens caused by one accepted beat and queues them.
    task automatic tokenize_beat(logic act, logic [7:0] c);
        logic        rescan;
        logic [31:0] pos;
        tok_rec_t    r;
        rescan     = 1'b0;
        step_count = 0;
        pos        = pos_r;
        if (act == ACT_END) begin
            flush_token();
        end else begin
            case (mode_r)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == "_") begin
                        if (tok_len_r < KW_CHARS) begin
                            kw_acc = {kw_acc[55:0], c};
                        end else begin
                            kw_ovf = 1'b1;
                        end
                        bump_len();
                    end else begin
                        close_word();
                        rescan = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        if (lead_zero_r) begin
                            tok_err_r = 1'b1;
                        end
                        bump_len();
                    end else begin
                        push_token(K_INT, tok_start_r, tok_len_r, tok_err_r);
                        rescan = 1'b1;
                    end
                end
                MODE_CBODY: begin
                    tok_start_r = pos;
                    tok_len_r   = 16'd1;
                    tok_err_r   = !char_value_ok(c);
                    mode_r      = MODE_CCLOSE;
                end
                MODE_CCLOSE: begin
                    if (c == "'") begin
                        push_token(K_CHAR, tok_start_r, tok_len_r, tok_err_r);
                        mode_r = MODE_IDLE;
                    end else begin
                        push_token(K_CHAR, tok_start_r, tok_len_r, 1'b1);
                        rescan = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (c == "\"") begin
                        push_token(K_STR, tok_start_r, tok_len_r, tok_err_r);
                        mode_r = MODE_IDLE;
                    end else begin
                        if (c < " " || c > "~") begin
                            tok_err_r = 1'b1;
                        end
                        bump_len();
                    end
                end
                MODE_OPER: begin
                    if (c == "=") begin
                        push_token(op_with_eq_kind(op_r), tok_start_r, 16'd2, 1'b0);
                        mode_r = MODE_IDLE;
                    end else begin
                        close_operator();
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                begin_token(c, pos);
            end
            pos_r = pos + 1;
        end
        // The final token of the beat carries tlast.
        if (step_count > 0) begin
            r = expected_tokens[expected_tokens.size() - 1];
            r.last = 1'b1;
            expected_tokens[expected_tokens.size() - 1] = r;
        end
    endtask

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offers one beat, waits for the handshake, then predicts its tokens.
    // tvalid stays high afterwards so back-to-back beats follow without a gap.
    task automatic send_beat(input logic act, input logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        tokenize_beat(act, b);
        sent_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(ACT_BYTE, s[i]);
        end
    endtask

    function automatic logic [7:0] word_char(logic first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r == 52) begin
            return "_";
        end
        return 8'("0" + r - 53);
    endfunction

    // Emits C-like source built from token-shaped pieces, with some noise, broken
    // constants and end-of-input beats mixed in, until the item count is reached.
    task automatic send_random_source(int upto);
        int         n;
        logic [7:0] b;
        while (sent_items < upto) begin
            case ($urandom_range(0, 19))
                0, 1: send_text(kw_names[$urandom_range(0, NUM_KEYWORDS - 1)]);
                2, 3, 4: begin
                    n = $urandom_range(1, 9);
                    send_beat(ACT_BYTE, word_char(1'b1));
                    repeat (n - 1) send_beat(ACT_BYTE, word_char(1'b0));
                end
                5, 6: begin
                    n = $urandom_range(1, 5);
                    b = ($urandom_range(0, 2) == 0) ? "0" : 8'("0" + $urandom_range(0, 9));
                    send_beat(ACT_BYTE, b);
                    repeat (n - 1) send_beat(ACT_BYTE, 8'("0" + $urandom_range(0, 9)));
                end
                7: begin
                    send_beat(ACT_BYTE, "'");
                    b = $urandom_range(0, 1) ? word_char(1'b0) : 8'($urandom_range(0, 255));
                    send_beat(ACT_BYTE, b);
                    if ($urandom_range(0, 4) != 0) begin
                        send_beat(ACT_BYTE, "'");
                    end
                end
                8, 9: begin
                    send_beat(ACT_BYTE, "\"");
                    repeat ($urandom_range(0, 8)) begin
                        b = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(32, 126))
                                                         : 8'($urandom_range(0, 255));
                        send_beat(ACT_BYTE, b);
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        send_beat(ACT_BYTE, "\"");
                    end
                end
                10, 11, 12, 13: send_text(op_texts[$urandom_range(0, 19)]);
                14, 15, 16: send_beat(ACT_BYTE, blank_bytes[$urandom_range(0, 5)]);
                17: send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
                18: send_beat(ACT_END, 8'($urandom_range(0, 255)));
                default: begin
                    // A keyword with more characters behind it must fall back to an
                    // identifier once the prefix overflows or stops matching.
                    send_text(kw_names[$urandom_range(0, NUM_KEYWORDS - 1)]);
                    send_beat(ACT_BYTE, word_char(1'b0));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sink side
    // ------------------------------------------------------------------

    // Drives m_tready: random stall bursts, and one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Each accepted token is checked against the oldest prediction.
    always @(posedge clk) begin : check_tokens
        tok_rec_t got;
        tok_rec_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind  = m_tuser[5:0];
            got.err   = m_tuser[6];
            got.start = m_tdata[31:0];
            got.len   = m_tdata[47:32];
            got.line  = m_tdata[71:48];
            got.last  = m_tlast;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected token: kind %0d start %0d len %0d line %0d err %0b last %0b",
                             got.kind, got.start, got.len, got.line, got.err, got.last);
                end
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.len !== want.len || got.line !== want.line ||
                    got.err !== want.err || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("token mismatch: expected kind %0d start %0d len %0d line %0d err %0b last %0b",
                                 want.kind, want.start, want.len, want.line, want.err, want.last);
                        $display("                got      kind %0d start %0d len %0d line %0d err %0b last %0b",
                                 got.kind, got.start, got.len, got.line, got.err, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: a run that stops moving on both sides is a hang.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A short hand-built source that hits each special case once: a keyword with
    // an extra letter, a newline, a lone zero and a leading zero, a bad char
    // value, a proper != and a lone bang, a string with a newline and a DEL byte,
    // an empty string, an unclosed char constant, the byte extremes as dropped
    // noise, and end of input right after a quote and again with nothing pending.
    task automatic test_special_cases();
        send_text("returns\n0 07'?'!=!x\"\n");
        send_beat(ACT_BYTE, 8'h7F);
        send_text("\"\"\"'ab");
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'hFF);
        send_text("<'");
        send_beat(ACT_END, 8'hFF);
        send_beat(ACT_END, 8'h00);
    endtask

    task automatic test_random_source();
        send_random_source(sent_items + 1200);
    endtask

    // The receiver stops for a long stretch while the source keeps offering beats,
    // so the result register and the input stage fill and s_tready drops.
    task automatic test_output_stall();
        hold_req = 1'b1;
        send_random_source(sent_items + 120);
    endtask

    // The closing stretch runs with both sides always ready.
    task automatic test_final_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_source(sent_items + 200);
    endtask

    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= ACT_BYTE;

        mode_r      = MODE_IDLE;
        kw_acc      = '0;
        kw_ovf      = 1'b0;
        op_r        = OP_LSS;
        tok_start_r = '0;
        tok_len_r   = '0;
        tok_err_r   = 1'b0;
        lead_zero_r = 1'b0;
        pos_r       = '0;
        line_r      = 24'd1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_random_source();
        test_output_stall();
        test_final_no_idle();

        // Let every predicted token come out, then wait on a little so that any
        // extra token would show up as unexpected.
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cts_pkg.sv
src/c_subset_token_scanner.sv
tb/sv/tb_c_subset_token_scanner.sv
